// ----- hdl/mstp_pkg.sv -----
package mstp_pkg;

    localparam int NODE_W     = 7;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTED   = 1'b1;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic              clear;
        logic              relax;
        logic              mark;
        logic [NODE_W-1:0] sel_node;
    } cell_ctl_t;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [NODE_W-1:0] node;
    } tok_t;

endpackage

// ----- hdl/mstp_ifs.sv -----
interface mstp_req_if #(parameter int WEIGHT_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic [mstp_pkg::CMD_W-1:0]    command;
    logic [mstp_pkg::NODE_W-1:0]   node_a;
    logic [mstp_pkg::NODE_W-1:0]   node_b;
    logic signed [WEIGHT_BITS-1:0] weight;

    modport source (output valid, command, node_a, node_b, weight, input ready);
    modport sink   (input valid, command, node_a, node_b, weight, output ready);
endinterface

interface mstp_rsp_if #(parameter int WEIGHT_BITS = 16) ();
    logic                          valid;
    logic                          ready;
    logic [mstp_pkg::NODE_W-1:0]   node_index;
    logic [mstp_pkg::NODE_W-1:0]   parent_index;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic                          reached;
    logic                          last;

    modport source (output valid, node_index, parent_index, edge_weight, reached, last,
                    input ready);
    modport sink   (input valid, node_index, parent_index, edge_weight, reached, last,
                    output ready);
endinterface

interface mstp_cfg_if ();
    logic                              valid;
    logic                              ready;
    logic [mstp_pkg::CFG_IDX_W-1:0]    index;
    logic [mstp_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/minimum_spanning_tree_prim_top.sv -----
// channel | dir | beat
// --------+-----+---------------------------------------------------------
// req     | in  | command, node_a, node_b, weight
// rsp     | out | node_index, parent_index, edge_weight, reached, last
// cfg     | in  | index, data (0: node_count, 1: directed_mode)
//
// Add: read and write back the edge (RD1, WR1); undirected also the reverse (RD2, WR2).
// Clear: sweep over every edge-memory entry. Run: one pass down the cell chain per
// selected node plus one, then one beat per node.
// Reset starts the same sweep; req.ready stays low then.
// rsp holds its beat under stall; emission waits for the output register.
module minimum_spanning_tree_prim_top #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    mstp_req_if.sink   req,
    mstp_rsp_if.source rsp,
    mstp_cfg_if.sink   cfg
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int NW     = mstp_pkg::NODE_W;
    localparam logic [NW-1:0]       MAX_N  = NW'(MAX_NODES);
    localparam logic [IDX_W:0]      PC_END = (IDX_W+1)'(MAX_NODES);

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_RD1  = 9'b000000100,
        S_WR1  = 9'b000001000,
        S_RD2  = 9'b000010000,
        S_WR2  = 9'b000100000,
        S_INIT = 9'b001000000,
        S_PASS = 9'b010000000,
        S_EMIT = 9'b100000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [IDX_W-1:0]              a_reg, a_next, b_reg, b_next;
    logic signed [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic [NW-1:0]                 cnt_reg;
    logic                          dir_reg;
    logic [IDX_W-1:0]              sel_reg, sel_next;
    logic                          relax_reg, relax_next;
    logic [IDX_W:0]                pc_reg, pc_next;
    logic                          inject_reg;
    logic [ADDR_W-1:0]             clr_reg, clr_next;
    logic [IDX_W-1:0]              emit_reg, emit_next;

    logic                          out_valid_reg;
    logic [NW-1:0]                 out_node_reg, out_par_reg;
    logic signed [WEIGHT_BITS-1:0] out_w_reg;
    logic                          out_reached_reg, out_last_reg;

    logic                          we;
    logic [ADDR_W-1:0]             waddr, raddr;
    logic [WEIGHT_BITS:0]          wdata, rdata;
    logic                          rd_present;
    logic signed [WEIGHT_BITS-1:0] rd_weight;

    mstp_pkg::cell_ctl_t           ctl;
    mstp_pkg::tok_t                tok_w [MAX_NODES+1];
    logic signed [WEIGHT_BITS-1:0] tkey_w [MAX_NODES+1];
    logic                          vis_w [MAX_NODES];
    logic signed [WEIGHT_BITS-1:0] key_w [MAX_NODES];
    logic [NW-1:0]                 par_w [MAX_NODES];

    mstp_pkg::tok_t                last_tok;
    logic [IDX_W-1:0]              found_idx;
    logic [NW-1:0]                 a_m1, b_m1, cnt_clamp, n_m1;
    logic                          add_ok, upd, out_load, emit_last;

    assign rd_present = rdata[WEIGHT_BITS];
    assign rd_weight  = rdata[WEIGHT_BITS-1:0];
    assign last_tok   = tok_w[MAX_NODES];
    assign a_m1       = req.node_a - NW'(1);
    assign b_m1       = req.node_b - NW'(1);
    assign found_idx  = IDX_W'(last_tok.node - NW'(1));
    assign n_m1       = n_reg - NW'(1);
    assign emit_last  = (NW'(emit_reg) == n_m1);
    assign upd        = !rd_present || w_reg < rd_weight;
    assign add_ok     = req.node_a != '0 && req.node_a <= MAX_N
                        && req.node_b != '0 && req.node_b <= MAX_N;
    assign out_load   = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        if (cnt_reg == '0)
            cnt_clamp = NW'(1);
        else if (cnt_reg > MAX_N)
            cnt_clamp = MAX_N;
        else
            cnt_clamp = cnt_reg;
    end

    mstp_edge_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (WEIGHT_BITS + 1)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign tok_w[0]  = '{valid: inject_reg, found: 1'b0, node: '0};
    assign tkey_w[0] = '0;

    for (genvar g = 0; g < MAX_NODES; g++)
    begin : g_cell
        mstp_cell #(
            .WEIGHT_BITS (WEIGHT_BITS),
            .NODE_ID     (NW'(g + 1))
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .n           (n_reg),
            .ctl         (ctl),
            .rd_present  (rd_present),
            .rd_weight   (rd_weight),
            .tok_in      (tok_w[g]),
            .tok_key_in  (tkey_w[g]),
            .tok_out     (tok_w[g+1]),
            .tok_key_out (tkey_w[g+1]),
            .visited     (vis_w[g]),
            .key         (key_w[g]),
            .parent      (par_w[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        w_next     = w_reg;
        n_next     = n_reg;
        sel_next   = sel_reg;
        relax_next = relax_reg;
        pc_next    = (pc_reg == PC_END) ? pc_reg : pc_reg + 1'b1;
        clr_next   = clr_reg;
        emit_next  = emit_reg;
        we         = 1'b0;
        waddr      = {a_reg, b_reg};
        wdata      = {1'b1, w_reg};
        raddr      = {sel_reg, pc_reg[IDX_W-1:0]};
        ctl.clear    = 1'b0;
        ctl.relax    = relax_reg;
        ctl.mark     = 1'b0;
        ctl.sel_node = NW'(sel_reg) + NW'(1);

        unique case (state_reg)
            S_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.command)
                        mstp_pkg::CMD_ADD:
                        begin
                            a_next = a_m1[IDX_W-1:0];
                            b_next = b_m1[IDX_W-1:0];
                            w_next = req.weight;
                            if (add_ok)
                                state_next = S_RD1;
                        end
                        mstp_pkg::CMD_RUN:
                        begin
                            n_next     = cnt_clamp;
                            state_next = S_INIT;
                        end
                        mstp_pkg::CMD_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                raddr      = {a_reg, b_reg};
                state_next = S_WR1;
            end
            S_WR1:
            begin
                we         = upd;
                state_next = dir_reg ? S_IDLE : S_RD2;
            end
            S_RD2:
            begin
                raddr      = {b_reg, a_reg};
                state_next = S_WR2;
            end
            S_WR2:
            begin
                we         = upd;
                waddr      = {b_reg, a_reg};
                state_next = S_IDLE;
            end
            S_INIT:
            begin
                ctl.clear  = 1'b1;
                relax_next = 1'b0;
                sel_next   = '0;
                pc_next    = '0;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                if (last_tok.valid)
                begin
                    if (last_tok.found)
                    begin
                        ctl.mark     = 1'b1;
                        ctl.sel_node = last_tok.node;
                        sel_next     = found_idx;
                        relax_next   = 1'b1;
                        pc_next      = '0;
                    end
                    else
                    begin
                        emit_next  = '0;
                        state_next = S_EMIT;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    emit_next = emit_reg + 1'b1;
                    if (emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            pc_reg        <= PC_END;
            inject_reg    <= 1'b0;
            relax_reg     <= 1'b0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= mstp_pkg::NODE_COUNT_RST;
            dir_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pc_reg     <= pc_next;
            inject_reg <= (state_reg == S_PASS) && (pc_reg == '0);
            relax_reg  <= relax_next;
            emit_reg   <= emit_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    mstp_pkg::CFG_NODE_COUNT: cnt_reg <= cfg.data;
                    mstp_pkg::CFG_DIRECTED:   dir_reg <= cfg.data[0];
                    default:                  dir_reg <= dir_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        w_reg   <= w_next;
        n_reg   <= n_next;
        sel_reg <= sel_next;
        if (out_load)
        begin
            out_node_reg    <= NW'(emit_reg) + NW'(1);
            out_reached_reg <= vis_w[emit_reg];
            out_last_reg    <= emit_last;
            if (vis_w[emit_reg] && emit_reg != '0)
            begin
                out_par_reg <= par_w[emit_reg];
                out_w_reg   <= key_w[emit_reg];
            end
            else
            begin
                out_par_reg <= '0;
                out_w_reg   <= '0;
            end
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = out_valid_reg;
    assign rsp.node_index   = out_node_reg;
    assign rsp.parent_index = out_par_reg;
    assign rsp.edge_weight  = out_w_reg;
    assign rsp.reached      = out_reached_reg;
    assign rsp.last         = out_last_reg;

`ifndef ASSERT_OFF
    a_sel_unvisited: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS && last_tok.valid && last_tok.found) |-> !vis_w[found_idx])
        else $error("selected node already in tree");

    a_unreached_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.reached) |-> (rsp.parent_index == '0 && rsp.edge_weight == '0))
        else $error("unreached node carries a parent");

    a_last_node: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.last) |-> (rsp.node_index == n_reg))
        else $error("last beat not on final node");

    a_no_req_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PASS || state_reg == S_EMIT || state_reg == S_CLR) |-> !req.ready)
        else $error("request taken while busy");
`endif

endmodule

// ----- hdl/mstp_edge_mem.sv -----
module mstp_edge_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/mstp_cell.sv -----
module mstp_cell #(
    parameter int                            WEIGHT_BITS = 16,
    parameter logic [mstp_pkg::NODE_W-1:0]   NODE_ID     = 7'd1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [mstp_pkg::NODE_W-1:0]   n,
    input  mstp_pkg::cell_ctl_t           ctl,
    input  logic                          rd_present,
    input  logic signed [WEIGHT_BITS-1:0] rd_weight,
    input  mstp_pkg::tok_t                tok_in,
    input  logic signed [WEIGHT_BITS-1:0] tok_key_in,
    output mstp_pkg::tok_t                tok_out,
    output logic signed [WEIGHT_BITS-1:0] tok_key_out,
    output logic                          visited,
    output logic signed [WEIGHT_BITS-1:0] key,
    output logic [mstp_pkg::NODE_W-1:0]   parent
);

    logic                          visited_reg;
    logic                          kf_reg;
    logic signed [WEIGHT_BITS-1:0] key_reg;
    logic [mstp_pkg::NODE_W-1:0]   parent_reg;
    mstp_pkg::tok_t                tok_reg, tok_next;
    logic signed [WEIGHT_BITS-1:0] tok_key_reg, tok_key_next;

    logic                          active;
    logic                          relax_hit;
    logic                          kf_upd;
    logic signed [WEIGHT_BITS-1:0] key_upd;
    logic                          take;

    always_comb
    begin
        active    = tok_in.valid && (NODE_ID <= n);
        relax_hit = ctl.relax && rd_present && !visited_reg
                    && (!kf_reg || rd_weight < key_reg);
        kf_upd    = kf_reg || relax_hit;
        key_upd   = relax_hit ? rd_weight : key_reg;
        // <= keeps the later node on equal keys
        take      = active && !visited_reg && kf_upd
                    && (!tok_in.found || key_upd <= tok_key_in);

        tok_next.valid = tok_in.valid;
        tok_next.found = tok_in.found || take;
        tok_next.node  = take ? NODE_ID : tok_in.node;
        tok_key_next   = take ? key_upd : tok_key_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
            kf_reg      <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (ctl.clear)
            begin
                visited_reg <= 1'b0;
                kf_reg      <= (NODE_ID == 7'd1);
            end
            else
            begin
                if (ctl.mark && ctl.sel_node == NODE_ID)
                begin
                    visited_reg <= 1'b1;
                end
                if (active && relax_hit)
                begin
                    kf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_key_reg <= tok_key_next;
        if (ctl.clear)
        begin
            key_reg    <= '0;
            parent_reg <= '0;
        end
        else if (active && relax_hit)
        begin
            key_reg    <= rd_weight;
            parent_reg <= ctl.sel_node;
        end
    end

    assign tok_out     = tok_reg;
    assign tok_key_out = tok_key_reg;
    assign visited     = visited_reg;
    assign key         = key_reg;
    assign parent      = parent_reg;

endmodule
